### hdl/evis_pkg.sv
// ----------------------------------------------------------------------------
// evis_pkg
// shared types and constants of the event interval statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package evis_pkg;

    localparam int TIME_W  = 24;
    localparam int CNT_W   = 16;
    localparam int SUM_W   = 40;
    localparam int SQ_W    = 64;
    localparam int OUT_W   = 40;
    localparam int CV_W    = 24;
    localparam int ALU_W   = 80;
    localparam int SHIFT_W = 112;

    localparam logic [CNT_W-1:0] MAX_INTERVALS = 16'd65535;
    localparam logic [CV_W-1:0]  CV_MAX        = 24'hFFFFFF;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FEW       = 2'd1,
        STAT_ZERO_MEAN = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_CHECK,
        ST_DIV_MEAN,
        ST_MUL_NQ,
        ST_MUL_SS,
        ST_NUM,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DIV_CV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic              last_event;
    } t_evis_in;

    typedef struct packed {
        logic [OUT_W-1:0] mean_interval;
        logic [OUT_W-1:0] std_interval;
        logic [CV_W-1:0]  variation_coeff;
        logic [CNT_W-1:0] interval_count;
        logic [1:0]       status;
    } t_evis_out;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } t_alu_rsp;

endpackage

`default_nettype wire

### hdl/evis_alu.sv
// ----------------------------------------------------------------------------
// evis_alu
// shared wide add/subtract unit, carry out doubles as a >= compare
// ----------------------------------------------------------------------------
`default_nettype none

module evis_alu
    import evis_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [ALU_W-1:0] w_b;
    logic [ALU_W:0]   w_full;

    // subtract as a + ~b + 1, carry set when a >= b
    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.sum   = w_full[ALU_W-1:0];
    assign o_rsp.carry = w_full[ALU_W];

endmodule

`default_nettype wire

### hdl/event_interval_statistics.sv
// ----------------------------------------------------------------------------
// event_interval_statistics
// interval mean, sample standard deviation and coefficient of variation
// ----------------------------------------------------------------------------
// Each input transaction carries one event timestamp on a 24-bit wrapping
// tick counter. From the second event of a set on, the modulo 2^24 interval
// to the previous event is counted and summed, together with its square.
// The event marked last closes the set and produces one output transaction:
// mean (Q24.16), sample standard deviation (Q24.16, divisor n-1) and
// coefficient of variation (Q8.16, saturating), plus the interval count and
// a status code; then all accumulators return to zero. An ordinary event
// passes through capture, square and accumulate. A closing event with at
// least two intervals and a nonzero sum runs the mean divide, two shift-add
// multiplies and a subtract to form n*sum_sq - sum^2, the variance divide,
// the square root and the coefficient divide; a closing event with a status
// other than ok goes straight to the output. All of this runs one bit or
// one digit per cycle through a single shared 80-bit add/subtract unit.
// The closing step may wait while an earlier result is still held on a
// stalled output. The input stall is high whenever the sequencer is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module event_interval_statistics
    import evis_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  wire t_evis_in  i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output t_evis_out      o_out_data
);

    // sequencer
    t_state r_state, n_state;
    logic [6:0] r_iter, n_iter;

    // set accumulators
    logic [TIME_W-1:0] r_prev, n_prev;
    logic              r_have, n_have;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_s, n_s;
    logic [SQ_W-1:0]   r_q, n_q;

    // per event captures
    logic [TIME_W-1:0] r_d, n_d;
    logic              r_take, n_take;
    logic              r_last, n_last;

    // shared datapath registers
    logic [ALU_W-1:0]   r_acc, n_acc;   // product, remainder or root remainder
    logic [SHIFT_W-1:0] r_rq, n_rq;     // dividend/quotient shift line
    logic [SUM_W-1:0]   r_div, n_div;   // divisor
    logic [OUT_W:0]     r_root, n_root; // root being built

    // results
    logic [OUT_W-1:0] r_mean, n_mean;
    logic [OUT_W-1:0] r_sd, n_sd;
    logic [CV_W-1:0]  r_cv, n_cv;
    t_status          r_status, n_status;

    // output register
    logic      r_ovalid, n_ovalid;
    t_evis_out r_out, n_out;

    // shared unit
    t_alu_req w_req;
    t_alu_rsp w_rsp;

    logic [2*TIME_W-1:0] w_sq;
    logic [2*CNT_W-1:0]  w_nn;
    logic [SUM_W:0]      w_rem_div;
    logic [ALU_W-1:0]    w_rem_sqrt;
    logic                w_load;

    evis_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_sq = {{TIME_W{1'b0}}, r_d} * {{TIME_W{1'b0}}, r_d};
    assign w_nn = {{CNT_W{1'b0}}, r_cnt} * {{CNT_W{1'b0}}, r_cnt - 16'd1};

    // restoring divide: bring down the next dividend bit
    assign w_rem_div  = {r_acc[SUM_W-1:0], r_rq[SHIFT_W-1]};
    // digit-by-digit root: bring down the next two radicand bits
    assign w_rem_sqrt = {r_acc[ALU_W-3:0], r_rq[81:80]};

    assign w_load = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_prev   = r_prev;
        n_have   = r_have;
        n_cnt    = r_cnt;
        n_s      = r_s;
        n_q      = r_q;
        n_d      = r_d;
        n_take   = r_take;
        n_last   = r_last;
        n_acc    = r_acc;
        n_rq     = r_rq;
        n_div    = r_div;
        n_root   = r_root;
        n_mean   = r_mean;
        n_sd     = r_sd;
        n_cv     = r_cv;
        n_status = r_status;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        w_req    = '{a: '0, b: '0, sub: 1'b0};

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    // interval wraps with the tick counter
                    n_d    = i_in_data.event_time - r_prev;
                    n_take = r_have && (r_cnt != MAX_INTERVALS);
                    n_last = i_in_data.last_event;
                    n_prev = i_in_data.event_time;
                    n_have = 1'b1;
                    n_state = ST_SQUARE;
                end
            end

            ST_SQUARE: begin
                n_acc   = {{(ALU_W-2*TIME_W){1'b0}}, w_sq};
                n_state = ST_ACCUM;
            end

            ST_ACCUM: begin
                w_req = '{a: {{(ALU_W-SQ_W){1'b0}}, r_q}, b: r_acc, sub: 1'b0};
                if (r_take) begin
                    n_q   = w_rsp.sum[SQ_W-1:0];
                    n_s   = r_s + {{(SUM_W-TIME_W){1'b0}}, r_d};
                    n_cnt = r_cnt + 16'd1;
                end
                n_state = r_last ? ST_CHECK : ST_IDLE;
            end

            ST_CHECK: begin
                priority if (r_cnt < 16'd2) begin
                    n_status = STAT_FEW;
                    n_mean   = '0;
                    n_sd     = '0;
                    n_cv     = '0;
                    n_state  = ST_DONE;
                end else if (r_s == '0) begin
                    n_status = STAT_ZERO_MEAN;
                    n_mean   = '0;
                    n_sd     = '0;
                    n_cv     = CV_MAX;
                    n_state  = ST_DONE;
                end else begin
                    // mean = sum * 2^16 / n, 56-bit dividend at the top
                    n_status = STAT_OK;
                    n_rq     = {r_s, 16'd0, 56'd0};
                    n_div    = {{(SUM_W-CNT_W){1'b0}}, r_cnt};
                    n_acc    = '0;
                    n_iter   = 7'd55;
                    n_state  = ST_DIV_MEAN;
                end
            end

            ST_DIV_MEAN, ST_DIV_VAR, ST_DIV_CV: begin
                w_req = '{a: {{(ALU_W-SUM_W-1){1'b0}}, w_rem_div},
                          b: {{(ALU_W-SUM_W){1'b0}}, r_div},
                          sub: 1'b1};
                n_acc  = w_rsp.carry ? w_rsp.sum
                                     : {{(ALU_W-SUM_W-1){1'b0}}, w_rem_div};
                n_rq   = {r_rq[SHIFT_W-2:0], w_rsp.carry};
                n_iter = r_iter - 7'd1;
                if (r_iter == 7'd0) begin
                    unique case (r_state)
                        ST_DIV_MEAN: begin
                            n_mean  = n_rq[OUT_W-1:0];
                            n_acc   = '0;
                            n_iter  = 7'd15;
                            n_state = ST_MUL_NQ;
                        end
                        ST_DIV_VAR: begin
                            n_acc   = '0;
                            n_root  = '0;
                            n_iter  = 7'd40;
                            n_state = ST_SQRT;
                        end
                        default: begin
                            // saturate when the quotient spills past 24 bits
                            n_cv    = (n_rq[55:24] != '0) ? CV_MAX : n_rq[CV_W-1:0];
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_MUL_NQ: begin
                // shift-add, msb of n first
                w_req = '{a: {r_acc[ALU_W-2:0], 1'b0},
                          b: r_cnt[r_iter[3:0]] ? {{(ALU_W-SQ_W){1'b0}}, r_q} : '0,
                          sub: 1'b0};
                n_acc  = w_rsp.sum;
                n_iter = r_iter - 7'd1;
                if (r_iter == 7'd0) begin
                    n_rq    = {{(SHIFT_W-ALU_W){1'b0}}, w_rsp.sum};
                    n_acc   = '0;
                    n_iter  = 7'd39;
                    n_state = ST_MUL_SS;
                end
            end

            ST_MUL_SS: begin
                w_req = '{a: {r_acc[ALU_W-2:0], 1'b0},
                          b: r_s[r_iter[5:0]] ? {{(ALU_W-SUM_W){1'b0}}, r_s} : '0,
                          sub: 1'b0};
                n_acc  = w_rsp.sum;
                n_iter = r_iter - 7'd1;
                if (r_iter == 7'd0) begin
                    n_state = ST_NUM;
                end
            end

            ST_NUM: begin
                // n*sum_sq - sum^2, then scale by 2^32 for the variance divide
                w_req   = '{a: r_rq[ALU_W-1:0], b: r_acc, sub: 1'b1};
                n_rq    = {w_rsp.sum, 32'd0};
                n_acc   = '0;
                n_div   = {{(SUM_W-2*CNT_W){1'b0}}, w_nn};
                n_iter  = 7'd111;
                n_state = ST_DIV_VAR;
            end

            ST_SQRT: begin
                w_req  = '{a: w_rem_sqrt,
                           b: {{(ALU_W-OUT_W-3){1'b0}}, r_root, 2'b01},
                           sub: 1'b1};
                n_acc  = w_rsp.carry ? w_rsp.sum : w_rem_sqrt;
                n_root = {r_root[OUT_W-1:0], w_rsp.carry};
                n_rq   = {r_rq[SHIFT_W-3:0], 2'b00};
                n_iter = r_iter - 7'd1;
                if (r_iter == 7'd0) begin
                    // cv = sd * 2^16 / mean
                    n_sd    = n_root[OUT_W-1:0];
                    n_rq    = {n_root[OUT_W-1:0], 16'd0, 56'd0};
                    n_div   = r_mean;
                    n_acc   = '0;
                    n_iter  = 7'd55;
                    n_state = ST_DIV_CV;
                end
            end

            ST_DONE: begin
                if (w_load) begin
                    n_out.mean_interval   = r_mean;
                    n_out.std_interval    = r_sd;
                    n_out.variation_coeff = r_cv;
                    n_out.interval_count  = r_cnt;
                    n_out.status          = r_status;
                    n_ovalid = 1'b1;
                    // close the set
                    n_prev  = '0;
                    n_have  = 1'b0;
                    n_cnt   = '0;
                    n_s     = '0;
                    n_q     = '0;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_prev   <= '0;
            r_have   <= 1'b0;
            r_cnt    <= '0;
            r_s      <= '0;
            r_q      <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_prev   <= n_prev;
            r_have   <= n_have;
            r_cnt    <= n_cnt;
            r_s      <= n_s;
            r_q      <= n_q;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_iter   <= n_iter;
        r_d      <= n_d;
        r_take   <= n_take;
        r_last   <= n_last;
        r_acc    <= n_acc;
        r_rq     <= n_rq;
        r_div    <= n_div;
        r_root   <= n_root;
        r_mean   <= n_mean;
        r_sd     <= n_sd;
        r_cv     <= n_cv;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
